@@ design/hbwd_pkg.sv @@
// ----------------------------------------------------------------------------
// hbwd_pkg
// shared types, constants and helpers for the heartbeat watchdog bank
// ----------------------------------------------------------------------------
package hbwd_pkg;

   // number of watched channels (1 to 32)
   localparam int CHANNELS = 18;

   // fixed field widths
   localparam int TimeW  = 32;
   localparam int ChanW  = 5;
   localparam int ErrW   = 18;
   localparam int GroupW = 7;
   localparam int CsrIdxW = 2;
   localparam int CsrDataW = 32;

   // derived widths
   localparam int ChIdxW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int CntW   = $clog2(CHANNELS + 1);

   // reset values of the timeout registers
   localparam logic [TimeW-1:0] RunTimeoutReset  = TimeW'(100);
   localparam logic [TimeW-1:0] InitTimeoutReset = TimeW'(1000);

   // opcodes
   localparam logic OP_BEAT = 1'b0;
   localparam logic OP_SCAN = 1'b1;

   // register indexes
   typedef enum logic [CsrIdxW-1:0] {
      CSR_CHANNEL_ENABLE = 2'd0,
      CSR_RUN_TIMEOUT    = 2'd1,
      CSR_INIT_TIMEOUT   = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_BEAT,
      ST_SCAN,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic             opcode;
      logic [ChanW-1:0] channel;
      logic [TimeW-1:0] now_ms;
   } req_type;

   typedef struct packed {
      logic [TimeW-1:0]  beat_interval_ms;
      logic [ErrW-1:0]   channel_errors;
      logic [GroupW-1:0] group_offline;
   } rsp_type;

   // per-channel flags handed to the scan evaluator
   typedef struct packed {
      logic running;
      logic pending;
   } scan_flags_type;

   // scan verdict for one channel
   typedef struct packed {
      logic open_window;
      logic err_set;
      logic err_clear;
   } scan_verdict_type;

   // fixed group masks over the error vector
   function automatic logic [GroupW-1:0] group_flags(input logic [ErrW-1:0] e);
      logic [GroupW-1:0] g;
      g[0] = e[4] | e[5] | e[6];
      g[1] = e[10] | e[11] | e[12];
      g[2] = e[0];
      g[3] = e[7] | e[8];
      g[4] = e[1];
      g[5] = e[9];
      g[6] = e[3];
      return g;
   endfunction

endpackage

@@ design/hbwd_ram.sv @@
// ----------------------------------------------------------------------------
// hbwd_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module hbwd_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 18
) (
   input  logic                                   clock,
   input  logic                                   we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                       wdata,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                       rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

@@ design/hbwd_scan_eval.sv @@
// ----------------------------------------------------------------------------
// hbwd_scan_eval
// timeout check of one channel during a scan
// ----------------------------------------------------------------------------
module hbwd_scan_eval (
   input  hbwd_pkg::scan_flags_type          flags,
   input  logic [hbwd_pkg::TimeW-1:0]        now_ms,
   input  logic [hbwd_pkg::TimeW-1:0]        beat_time,
   input  logic [hbwd_pkg::TimeW-1:0]        init_start,
   input  logic [hbwd_pkg::TimeW-1:0]        run_timeout,
   input  logic [hbwd_pkg::TimeW-1:0]        init_timeout,
   output hbwd_pkg::scan_verdict_type        verdict
);
   import hbwd_pkg::*;

   logic [TimeW-1:0] window_start;
   logic [TimeW-1:0] init_age;
   logic [TimeW-1:0] beat_age;

   // a fresh window starts now
   assign window_start = flags.pending ? init_start : now_ms;
   assign init_age     = now_ms - window_start;
   assign beat_age     = now_ms - beat_time;

   always_comb begin
      verdict = '0;
      if (!flags.running) begin
         verdict.open_window = !flags.pending;
         verdict.err_set     = init_age > init_timeout;
      end else begin
         verdict.err_set   = beat_age > run_timeout;
         verdict.err_clear = !(beat_age > run_timeout);
      end
   end

endmodule

@@ design/multi_channel_heartbeat_watchdog.sv @@
// ----------------------------------------------------------------------------
// multi_channel_heartbeat_watchdog
// bank of heartbeat watchdogs with shared timeouts and group offline flags
// ----------------------------------------------------------------------------
//
//   channel   ports                         handshake
//   -------   ---------------------------   ----------------------------------
//   request   start, busy, req_data         transfer when start & !busy
//   response  rsp_strobe, rsp_data          one-cycle strobe, no back-pressure
//   csr       csr_we, csr_index, csr_wdata  write when csr_we, no wait
//
// a heartbeat reads the beat time from ram on the transfer, updates in the
// beat state and registers the response in the response state
// a scan walks the channels one per cycle, reading both time rams and
// writing back one behind
// reset is synchronous and clears flags, registers and the sequencer; the
// time rams need no clearing pass since a stale entry is never used
// busy stays high from the transfer until the strobe is registered; the
// response side cannot stall
//
module multi_channel_heartbeat_watchdog (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  hbwd_pkg::req_type                 req_data,
   output logic                              rsp_strobe,
   output hbwd_pkg::rsp_type                 rsp_data,
   input  logic                              csr_we,
   input  logic [hbwd_pkg::CsrIdxW-1:0]      csr_index,
   input  logic [hbwd_pkg::CsrDataW-1:0]     csr_wdata
);
   import hbwd_pkg::*;

   // configuration registers
   logic [ErrW-1:0]  enable_ff;
   logic [TimeW-1:0] run_timeout_ff;
   logic [TimeW-1:0] init_timeout_ff;

   // sequencer
   state_type        state_ff, state_in;
   logic [CntW-1:0]  cnt_ff, cnt_in;
   req_type          req_ff, req_in;
   logic [TimeW-1:0] interval_ff, interval_in;

   // per-channel flags, kept in flops so reset clears them at once
   logic [CHANNELS-1:0] heard_ff, heard_in;
   logic [CHANNELS-1:0] running_ff, running_in;
   logic [CHANNELS-1:0] pending_ff, pending_in;
   logic [CHANNELS-1:0] error_ff, error_in;

   // response register
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;

   // ram ports
   logic [ChIdxW-1:0] rd_addr;
   logic [TimeW-1:0]  beat_rd;
   logic [TimeW-1:0]  init_rd;
   logic              beat_we;
   logic              init_we;

   // scan datapath
   logic [CntW-1:0]   proc_cnt;
   logic [ChIdxW-1:0] proc_idx;
   logic [ChIdxW-1:0] beat_idx;
   logic              beat_in_range;
   logic [CHANNELS-1:0] enable_vec;
   logic [ErrW-1:0]   err_vec;
   scan_flags_type    eval_flags;
   scan_verdict_type  verdict;

   // enable bits beyond the register width are off; errors beyond the bank
   // read as clear
   for (genvar gi = 0; gi < CHANNELS; gi++) begin : g_en
      if (gi < ErrW) begin : g_on
         assign enable_vec[gi] = enable_ff[gi];
      end else begin : g_off
         assign enable_vec[gi] = 1'b0;
      end
   end

   for (genvar gi = 0; gi < ErrW; gi++) begin : g_err
      if (gi < CHANNELS) begin : g_on
         assign err_vec[gi] = error_ff[gi];
      end else begin : g_off
         assign err_vec[gi] = 1'b0;
      end
   end

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff       <= '0;
         run_timeout_ff  <= RunTimeoutReset;
         init_timeout_ff <= InitTimeoutReset;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_CHANNEL_ENABLE: enable_ff       <= csr_wdata[ErrW-1:0];
            CSR_RUN_TIMEOUT:    run_timeout_ff  <= csr_wdata[TimeW-1:0];
            CSR_INIT_TIMEOUT:   init_timeout_ff <= csr_wdata[TimeW-1:0];
            default: ;
         endcase
      end
   end

   // ram addressing: a heartbeat reads its channel on the transfer, a scan
   // reads the channel at the counter while processing the one before
   assign beat_idx      = req_ff.channel[ChIdxW-1:0];
   assign beat_in_range = {1'b0, req_ff.channel} < (ChanW + 1)'(CHANNELS);
   assign proc_cnt      = cnt_ff - CntW'(1);
   assign proc_idx      = proc_cnt[ChIdxW-1:0];
   assign rd_addr       = (state_ff == ST_IDLE) ? req_data.channel[ChIdxW-1:0]
                                                : cnt_ff[ChIdxW-1:0];

   hbwd_ram #(
      .WIDTH (TimeW),
      .DEPTH (CHANNELS)
   ) u_beat_ram (
      .clock (clock),
      .we    (beat_we),
      .waddr (beat_idx),
      .wdata (req_ff.now_ms),
      .raddr (rd_addr),
      .rdata (beat_rd)
   );

   hbwd_ram #(
      .WIDTH (TimeW),
      .DEPTH (CHANNELS)
   ) u_init_ram (
      .clock (clock),
      .we    (init_we),
      .waddr (proc_idx),
      .wdata (req_ff.now_ms),
      .raddr (rd_addr),
      .rdata (init_rd)
   );

   assign eval_flags.running = running_ff[proc_idx];
   assign eval_flags.pending = pending_ff[proc_idx];

   hbwd_scan_eval u_scan_eval (
      .flags        (eval_flags),
      .now_ms       (req_ff.now_ms),
      .beat_time    (beat_rd),
      .init_start   (init_rd),
      .run_timeout  (run_timeout_ff),
      .init_timeout (init_timeout_ff),
      .verdict      (verdict)
   );

   // sequencer state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         heard_ff     <= '0;
         running_ff   <= '0;
         pending_ff   <= '0;
         error_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         heard_ff     <= heard_in;
         running_ff   <= running_in;
         pending_ff   <= pending_in;
         error_ff     <= error_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      interval_ff <= interval_in;
      rsp_ff      <= rsp_in;
   end

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      req_in       = req_ff;
      interval_in  = interval_ff;
      heard_in     = heard_ff;
      running_in   = running_ff;
      pending_in   = pending_ff;
      error_in     = error_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      beat_we      = 1'b0;
      init_we      = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               req_in      = req_data;
               interval_in = '0;
               cnt_in      = '0;
               state_in    = (req_data.opcode == OP_SCAN) ? ST_SCAN : ST_BEAT;
            end
         end

         ST_BEAT: begin
            // beat time of the channel is on the ram output now
            if (beat_in_range) begin
               beat_we            = 1'b1;
               heard_in[beat_idx] = 1'b1;
               if (heard_ff[beat_idx]) begin
                  interval_in          = req_ff.now_ms - beat_rd;
                  running_in[beat_idx] = 1'b1;
               end
            end
            state_in = ST_RESP;
         end

         ST_SCAN: begin
            cnt_in = cnt_ff + CntW'(1);
            // write back the channel read in the previous cycle
            if (cnt_ff != '0 && enable_vec[proc_idx]) begin
               if (verdict.open_window) begin
                  pending_in[proc_idx] = 1'b1;
                  init_we              = 1'b1;
               end
               if (verdict.err_set) begin
                  error_in[proc_idx] = 1'b1;
               end
               if (verdict.err_clear) begin
                  error_in[proc_idx]   = 1'b0;
                  pending_in[proc_idx] = 1'b0;
               end
            end
            if (cnt_ff == CntW'(CHANNELS)) begin
               state_in = ST_RESP;
            end
         end

         ST_RESP: begin
            // flags are final here
            rsp_valid_in            = 1'b1;
            rsp_in.beat_interval_ms = interval_ff;
            rsp_in.channel_errors   = err_vec;
            rsp_in.group_offline    = group_flags(err_vec);
            state_in                = ST_IDLE;
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = rsp_valid_ff;
   assign rsp_data   = rsp_ff;

endmodule

@@ sim/hbwd_response_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hbwd_response_checker
// watches the request, response and csr ports of the watchdog bank, keeps its
// own copy of the per-channel watchdog state and checks every response
// ----------------------------------------------------------------------------
module hbwd_response_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic                          busy,
   input  hbwd_pkg::req_type             req_data,
   input  logic                          rsp_strobe,
   input  hbwd_pkg::rsp_type             rsp_data,
   input  logic                          csr_we,
   input  logic [hbwd_pkg::CsrIdxW-1:0]  csr_index,
   input  logic [hbwd_pkg::CsrDataW-1:0] csr_wdata,
   output int                            failures,
   output int                            outstanding
);
   import hbwd_pkg::*;

   // channel membership of each offline group, group 6 first
   localparam logic [GroupW-1:0][ErrW-1:0] GROUP_MEMBERS = {
      18'h00008, 18'h00200, 18'h00002, 18'h00180, 18'h00001, 18'h01C00, 18'h00070
   };

   logic [CHANNELS-1:0] heard;
   logic [CHANNELS-1:0] live;
   logic [CHANNELS-1:0] window_open;
   logic [ErrW-1:0]     fault;
   logic [TimeW-1:0]    last_beat [CHANNELS];
   logic [TimeW-1:0]    window_origin [CHANNELS];
   logic [ErrW-1:0]     enable_mask;
   logic [TimeW-1:0]    run_limit;
   logic [TimeW-1:0]    init_limit;
   rsp_type             due_responses [$];
   int                  failure_count = 0;
   int                  due_count = 0;

   assign failures    = failure_count;
   assign outstanding = due_count;

   // one item through the watchdog bank
   task automatic step_watchdog(input req_type item, output rsp_type result);
      logic [TimeW-1:0] age;
      result = '0;
      if (item.opcode == OP_BEAT) begin
         if (item.channel < CHANNELS) begin
            if (!heard[item.channel]) begin
               heard[item.channel] = 1'b1;
            end else begin
               result.beat_interval_ms = item.now_ms - last_beat[item.channel];
               live[item.channel] = 1'b1;
            end
            last_beat[item.channel] = item.now_ms;
         end
      end else begin
         for (int i = 0; i < CHANNELS; i++) begin
            if (enable_mask[i]) begin
               if (!live[i]) begin
                  // init window opens on the first scan, error never clears here
                  if (!window_open[i]) begin
                     window_open[i]   = 1'b1;
                     window_origin[i] = item.now_ms;
                  end
                  age = item.now_ms - window_origin[i];
                  if (age > init_limit) fault[i] = 1'b1;
               end else begin
                  age = item.now_ms - last_beat[i];
                  if (age > run_limit) begin
                     fault[i] = 1'b1;
                  end else begin
                     fault[i]         = 1'b0;
                     window_open[i]   = 1'b0;
                     window_origin[i] = '0;
                  end
               end
            end
         end
      end
      result.channel_errors = fault;
      for (int k = 0; k < GroupW; k++) result.group_offline[k] = |(fault & GROUP_MEMBERS[k]);
   endtask

   task automatic check_field(input string name, input logic [TimeW-1:0] want,
                              input logic [TimeW-1:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %h actual %h", $time, name, want, got);
         failure_count++;
      end
   endtask

   always @(posedge clock) begin : watch
      rsp_type expected;
      if (reset) begin
         heard       = '0;
         live        = '0;
         window_open = '0;
         fault       = '0;
         for (int i = 0; i < CHANNELS; i++) begin
            last_beat[i]     = '0;
            window_origin[i] = '0;
         end
         enable_mask = '0;
         run_limit   = RunTimeoutReset;
         init_limit  = InitTimeoutReset;
         due_responses.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_CHANNEL_ENABLE: enable_mask = csr_wdata[ErrW-1:0];
               CSR_RUN_TIMEOUT:    run_limit = csr_wdata;
               CSR_INIT_TIMEOUT:   init_limit = csr_wdata;
               default: ;
            endcase
         end
         // response first so a transfer on the same edge cannot be matched by it
         if (rsp_strobe) begin
            if (due_responses.size() == 0) begin
               $display("%0t: response with none expected, actual %h", $time, rsp_data);
               failure_count++;
            end else begin
               expected = due_responses.pop_front();
               check_field("beat_interval_ms", expected.beat_interval_ms,
                           rsp_data.beat_interval_ms);
               check_field("channel_errors", TimeW'(expected.channel_errors),
                           TimeW'(rsp_data.channel_errors));
               check_field("group_offline", TimeW'(expected.group_offline),
                           TimeW'(rsp_data.group_offline));
            end
         end
         if (start && !busy) begin
            step_watchdog(req_data, expected);
            due_responses.push_back(expected);
         end
      end
      due_count <= due_responses.size();
   end

endmodule

@@ sim/multi_channel_heartbeat_watchdog_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_channel_heartbeat_watchdog_test
// drives heartbeat and scan commands into the watchdog bank through a series
// of timeout and enable settings; the checker beside the block predicts and
// compares every response, this module only makes stimulus and the verdict
// ----------------------------------------------------------------------------
module multi_channel_heartbeat_watchdog_test;
   import hbwd_pkg::*;

   localparam int PERIOD        = 10;
   localparam int RESET_CYCLES  = 6;
   localparam int PHASE_COUNT   = 10;
   localparam int PHASE_ITEMS   = 125;
   localparam int IDLE_PERCENT  = 22;
   // idle tail after a drain, sized from the length of a scan up to its response
   localparam int DRAIN_TAIL    = 2 * (CHANNELS + 3);
   localparam int CYCLE_LIMIT   = 250000;
   localparam logic [CsrIdxW-1:0]  CSR_UNUSED   = 2'd3;
   localparam logic [CsrDataW-1:0] ALL_ONES     = '1;
   localparam logic [CsrDataW-1:0] ALL_CHANNELS = CsrDataW'((64'd1 << CHANNELS) - 1);

   logic                clock     = 1'b0;
   logic                reset     = 1'b1;
   logic                start     = 1'b0;
   logic                busy;
   req_type             req_data  = '0;
   logic                rsp_strobe;
   rsp_type             rsp_data;
   logic                csr_we    = 1'b0;
   logic [CsrIdxW-1:0]  csr_index = '0;
   logic [CsrDataW-1:0] csr_wdata = '0;
   int                  failures;
   int                  outstanding;
   int                  cycle_count = 0;

   // shaping of the random items in the current phase
   bit                  idle_on     = 1'b1;
   bit                  noise_times = 1'b0;
   int                  step_max    = 10;
   int                  scan_percent = 30;
   logic [ErrW-1:0]     quiet_channels = '0;
   logic [TimeW-1:0]    ms_now      = 32'd2000;

   always #(PERIOD / 2) clock = ~clock;

   multi_channel_heartbeat_watchdog i_dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   hbwd_response_checker i_checker (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_data    (req_data),
      .rsp_strobe  (rsp_strobe),
      .rsp_data    (rsp_data),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .failures    (failures),
      .outstanding (outstanding)
   );

   // watchdog on the testbench itself
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d responses outstanding",
                  cycle_count, outstanding);
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // one command transfer; start drops at random while waiting, with junk on
   // the request bus, so gaps land on every cycle of a heartbeat or a scan
   task automatic send_item(input logic op, input logic [ChanW-1:0] ch,
                            input logic [TimeW-1:0] now);
      req_type item;
      req_type junk;
      bit      hold_off;
      item.opcode  = op;
      item.channel = ch;
      item.now_ms  = now;
      forever begin
         hold_off      = idle_on && ($urandom_range(0, 99) < IDLE_PERCENT);
         junk.opcode   = 1'($urandom_range(0, 1));
         junk.channel  = ChanW'($urandom_range(0, 31));
         junk.now_ms   = $urandom;
         start    <= !hold_off;
         req_data <= hold_off ? junk : item;
         @(posedge clock);
         if (start && !busy) break;
      end
   endtask

   // wait until every response is in, then let the block run out
   task automatic drain();
      start <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (DRAIN_TAIL) @(posedge clock);
   endtask

   // back to back register writes, only called while the block is idle
   task automatic load_settings(input logic [CsrDataW-1:0] enable_bits,
                                input logic [CsrDataW-1:0] run_ms,
                                input logic [CsrDataW-1:0] init_ms,
                                input bit poke_unused);
      csr_we    <= 1'b1;
      csr_index <= CSR_CHANNEL_ENABLE;
      csr_wdata <= enable_bits;
      @(posedge clock);
      csr_index <= CSR_RUN_TIMEOUT;
      csr_wdata <= run_ms;
      @(posedge clock);
      csr_index <= CSR_INIT_TIMEOUT;
      csr_wdata <= init_ms;
      @(posedge clock);
      if (poke_unused) begin
         // unmapped index must leave all three registers alone
         csr_index <= CSR_UNUSED;
         csr_wdata <= $urandom;
         @(posedge clock);
      end
      csr_we <= 1'b0;
   endtask

   task automatic set_phase(input int phase);
      logic [CsrDataW-1:0] enable_bits;
      logic [CsrDataW-1:0] run_ms;
      logic [CsrDataW-1:0] init_ms;
      bit                  poke_unused;
      idle_on        = 1'b1;
      noise_times    = 1'b0;
      step_max       = 10;
      scan_percent   = 30;
      quiet_channels = '0;
      poke_unused    = 1'b0;
      enable_bits    = ALL_CHANNELS;
      case (phase)
         0: begin
            // many channels never beat, so init windows run out
            quiet_channels = ErrW'($urandom) & ~(ErrW'(1) << $urandom_range(0, CHANNELS - 1));
            run_ms  = 200;
            init_ms = 400;
         end
         1: begin
            quiet_channels = ErrW'($urandom) & ~(ErrW'(1) << $urandom_range(0, CHANNELS - 1));
            enable_bits = $urandom;
            run_ms  = 120;
            init_ms = 250;
         end
         2: begin
            // zero timeouts, only a scan in the same ms as the beat passes
            enable_bits = ALL_ONES;
            run_ms   = 0;
            init_ms  = 0;
            step_max = 2;
         end
         3: begin
            // nothing enabled, scans leave every error as it was
            enable_bits  = '0;
            run_ms       = 50;
            init_ms      = 50;
            scan_percent = 40;
         end
         4: begin
            run_ms  = ALL_ONES;
            init_ms = ALL_ONES;
         end
         5: begin
            // time wraps through zero in this phase
            ms_now      = 32'hFFFF_F800;
            enable_bits = $urandom | 32'h3F;
            run_ms      = 150;
            init_ms     = 300;
            step_max    = 12;
         end
         6: begin
            noise_times  = 1'b1;
            enable_bits  = $urandom;
            run_ms       = $urandom;
            init_ms      = $urandom;
            scan_percent = 40;
         end
         7: begin
            // long stretch at full rate, back on the reset timeouts
            idle_on  = 1'b0;
            run_ms   = RunTimeoutReset;
            init_ms  = InitTimeoutReset;
            step_max = 12;
         end
         8: begin
            enable_bits = $urandom;
            run_ms      = $urandom_range(1, 300);
            init_ms     = $urandom_range(1, 600);
            step_max    = 15;
            poke_unused = 1'b1;
         end
         default: begin
            run_ms   = 30;
            init_ms  = 60;
            step_max = 4;
         end
      endcase
      load_settings(enable_bits, run_ms, init_ms, poke_unused);
   endtask

   task automatic send_random_item();
      logic             op;
      logic [ChanW-1:0] ch;
      logic [TimeW-1:0] now;
      if (noise_times) begin
         now = $urandom;
      end else begin
         // mostly small steps, now and then a jump anywhere
         if ($urandom_range(0, 99) < 3) ms_now = ms_now + $urandom;
         else ms_now = ms_now + TimeW'($urandom_range(0, step_max));
         now = ms_now;
      end
      op = ($urandom_range(0, 99) < scan_percent) ? OP_SCAN : OP_BEAT;
      if (op == OP_SCAN) begin
         ch = ChanW'($urandom_range(0, 31));
      end else if ($urandom_range(0, 99) < 6) begin
         // stray channel number past the bank
         ch = ChanW'($urandom_range(CHANNELS, 31));
      end else begin
         do ch = ChanW'($urandom_range(0, CHANNELS - 1)); while (quiet_channels[ch]);
      end
      send_item(op, ch, now);
   endtask

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // reset settings: nothing enabled, run 100, init 1000
      send_item(OP_SCAN, 5'd31, 32'd0);
      send_item(OP_BEAT, 5'd0, 32'd10);          // first beat, interval 0
      send_item(OP_BEAT, 5'd0, 32'd60);          // second beat, now running
      send_item(OP_BEAT, 5'd31, 32'd70);         // out of range channels
      send_item(OP_BEAT, 5'd18, 32'd70);
      send_item(OP_BEAT, 5'd17, 32'hFFFF_FFFF);  // first beat at top of time
      drain();
      load_settings(ALL_ONES, RunTimeoutReset, InitTimeoutReset, 1'b0);
      send_item(OP_SCAN, 5'd0, 32'd100);         // opens init windows
      send_item(OP_SCAN, 5'd0, 32'd1100);        // init exactly at the limit
      send_item(OP_SCAN, 5'd0, 32'd1101);        // one past the init limit
      send_item(OP_BEAT, 5'd17, 32'h0000_0010);  // interval across the wrap
      send_item(OP_BEAT, 5'd1, 32'd1150);
      send_item(OP_BEAT, 5'd1, 32'd1200);
      send_item(OP_SCAN, 5'd0, 32'd1210);        // ch1 clears, ch17 stale
      send_item(OP_BEAT, 5'd0, 32'd1250);
      send_item(OP_SCAN, 5'd0, 32'd1350);        // ch0 exactly at the run limit
      send_item(OP_SCAN, 5'd0, 32'd1351);

      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         drain();
         set_phase(phase);
         repeat (PHASE_ITEMS) send_random_item();
      end
      drain();

      if (failures == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

@@ files.f @@
design/hbwd_pkg.sv
design/hbwd_ram.sv
design/hbwd_scan_eval.sv
design/multi_channel_heartbeat_watchdog.sv
sim/hbwd_response_checker.sv
sim/multi_channel_heartbeat_watchdog_test.sv
